[rtl/uks_pkg.sv]
`timescale 1ns / 1ps

package uks_pkg;

  // Default number of entries held by the stack.
  localparam int STACK_DEPTH_DEF = 16;

  // Command codes carried in the cmd field.
  localparam logic [2:0] CMD_PUSH    = 3'd0;
  localparam logic [2:0] CMD_POP     = 3'd1;
  localparam logic [2:0] CMD_COUNT   = 3'd2;
  localparam logic [2:0] CMD_PEEK    = 3'd3;
  localparam logic [2:0] CMD_DISPLAY = 3'd4;

  // Status codes returned with every result.
  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_DUP   = 2'd1;
  localparam logic [1:0] STS_UNDER = 2'd2;
  localparam logic [1:0] STS_OVER  = 2'd3;

  // One input transaction.
  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] entry_key;
    logic signed [31:0] entry_value;
  } uks_in_t;

  // One result transaction.
  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] out_key;
    logic signed [31:0] out_value;
    logic [4:0]         occupancy;
    logic               last;
  } uks_out_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH,
    S_TOP,
    S_RESP,
    S_DISP_RD,
    S_DISP_OUT
  } uks_state_t;

endpackage

[rtl/uks_store.sv]
`timescale 1ns / 1ps

module uks_store #(
  parameter int DEPTH = uks_pkg::STACK_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic signed [31:0]   wr_key,
  input  logic signed [31:0]   wr_value,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output logic signed [31:0]   rd_key,
  output logic signed [31:0]   rd_value
);

  logic signed [31:0] key_mem [DEPTH];
  logic signed [31:0] value_mem [DEPTH];

  // Single write port; entries are not cleared at reset.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr]   <= wr_key;
      value_mem[wr_addr] <= wr_value;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_key   <= key_mem[rd_addr];
      rd_value <= value_mem[rd_addr];
    end
  end

endmodule

[rtl/unique_key_stack.sv]
`timescale 1ns / 1ps
// Pop, count, unused codes and peek or display on an empty stack go straight to the result
// state; peek first reads the top entry, and push first searches the stored entries (the
// duplicate search reads one stored entry per cycle through one compare). Display reads the
// entries from top to bottom, each with a memory read, then the result register.
// A new transaction is taken once the previous one has handed its final result to the output
// register. Synchronous active-low reset clears the fill level and control state only.
module unique_key_stack #(
  parameter int STACK_DEPTH = uks_pkg::STACK_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  uks_pkg::uks_in_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output uks_pkg::uks_out_t out_data
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int FW = $clog2(STACK_DEPTH + 1);

  uks_pkg::uks_state_t state_r, state_nxt;

  logic [2:0]         cmd_r, cmd_nxt;
  logic signed [31:0] key_r, key_nxt;
  logic signed [31:0] value_r, value_nxt;
  logic [FW-1:0]      fill_r, fill_nxt;
  logic [FW-1:0]      idx_r, idx_nxt;
  logic               pend_r, pend_nxt;
  logic               dup_r, dup_nxt;
  logic               out_valid_r, out_valid_nxt;
  uks_pkg::uks_out_t  out_data_r, out_data_nxt;

  logic               in_accept;
  logic               out_free;
  logic               out_load;
  logic               full;
  logic               match;
  logic [FW-1:0]      top_w;

  logic               wr_en;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic signed [31:0] rd_key;
  logic signed [31:0] rd_value;

  // Key and value memory.
  uks_store #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (fill_r[AW-1:0]),
    .wr_key   (key_r),
    .wr_value (value_r),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_key   (rd_key),
    .rd_value (rd_value)
  );

  // Handshake and shared compare.
  assign in_stall  = (state_r != uks_pkg::S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign full      = (fill_r == FW'(STACK_DEPTH));
  assign match     = (rd_key == key_r);
  assign top_w     = fill_r - FW'(1);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      uks_pkg::S_IDLE: begin
        if (in_accept) begin
          case (in_data.cmd)
            uks_pkg::CMD_PUSH:    state_nxt = uks_pkg::S_SRCH;
            uks_pkg::CMD_PEEK:    state_nxt = (fill_r == '0) ? uks_pkg::S_RESP
                                                             : uks_pkg::S_TOP;
            uks_pkg::CMD_DISPLAY: state_nxt = (fill_r == '0) ? uks_pkg::S_RESP
                                                             : uks_pkg::S_DISP_RD;
            default:              state_nxt = uks_pkg::S_RESP;
          endcase
        end
      end
      uks_pkg::S_SRCH: begin
        if ((pend_r && match) || (!pend_r && idx_r == fill_r)) begin
          state_nxt = uks_pkg::S_RESP;
        end
      end
      uks_pkg::S_TOP: state_nxt = uks_pkg::S_RESP;
      uks_pkg::S_RESP: begin
        if (out_free) begin
          state_nxt = uks_pkg::S_IDLE;
        end
      end
      uks_pkg::S_DISP_RD: state_nxt = uks_pkg::S_DISP_OUT;
      uks_pkg::S_DISP_OUT: begin
        if (out_free) begin
          state_nxt = (idx_r == '0) ? uks_pkg::S_IDLE : uks_pkg::S_DISP_RD;
        end
      end
      default: state_nxt = uks_pkg::S_IDLE;
    endcase
  end

  // Output and datapath control of the sequencer.
  always_comb begin
    cmd_nxt      = cmd_r;
    key_nxt      = key_r;
    value_nxt    = value_r;
    fill_nxt     = fill_r;
    idx_nxt      = idx_r;
    pend_nxt     = pend_r;
    dup_nxt      = dup_r;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = idx_r[AW-1:0];
    out_load     = 1'b0;
    out_data_nxt = out_data_r;
    unique case (state_r)
      uks_pkg::S_IDLE: begin
        if (in_accept) begin
          cmd_nxt   = in_data.cmd;
          key_nxt   = in_data.entry_key;
          value_nxt = in_data.entry_value;
          idx_nxt   = (in_data.cmd == uks_pkg::CMD_DISPLAY) ? top_w : '0;
          pend_nxt  = 1'b0;
          dup_nxt   = 1'b0;
        end
      end
      uks_pkg::S_SRCH: begin
        // Issue one read per cycle and compare the entry read the cycle before.
        if (pend_r && match) begin
          dup_nxt = 1'b1;
        end
        if (idx_r != fill_r) begin
          rd_en    = 1'b1;
          idx_nxt  = idx_r + FW'(1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
      end
      uks_pkg::S_TOP: begin
        rd_en   = 1'b1;
        rd_addr = top_w[AW-1:0];
      end
      uks_pkg::S_RESP: begin
        if (out_free) begin
          out_load               = 1'b1;
          out_data_nxt.status    = uks_pkg::STS_OK;
          out_data_nxt.out_key   = '0;
          out_data_nxt.out_value = '0;
          out_data_nxt.last      = 1'b1;
          case (cmd_r)
            uks_pkg::CMD_PUSH: begin
              if (dup_r) begin
                out_data_nxt.status = uks_pkg::STS_DUP;
              end else if (full) begin
                out_data_nxt.status = uks_pkg::STS_OVER;
              end else begin
                wr_en    = 1'b1;
                fill_nxt = fill_r + FW'(1);
              end
            end
            uks_pkg::CMD_POP: begin
              if (fill_r == '0) begin
                out_data_nxt.status = uks_pkg::STS_UNDER;
              end else begin
                fill_nxt = top_w;
              end
            end
            uks_pkg::CMD_PEEK: begin
              if (fill_r == '0) begin
                out_data_nxt.status = uks_pkg::STS_UNDER;
              end else begin
                out_data_nxt.out_key   = rd_key;
                out_data_nxt.out_value = rd_value;
              end
            end
            uks_pkg::CMD_DISPLAY: out_data_nxt.status = uks_pkg::STS_UNDER;
            default: ;
          endcase
          out_data_nxt.occupancy = 5'(fill_nxt);
        end
      end
      uks_pkg::S_DISP_RD: begin
        rd_en = 1'b1;
      end
      uks_pkg::S_DISP_OUT: begin
        if (out_free) begin
          out_load               = 1'b1;
          out_data_nxt.status    = uks_pkg::STS_OK;
          out_data_nxt.out_key   = rd_key;
          out_data_nxt.out_value = rd_value;
          out_data_nxt.occupancy = 5'(fill_r);
          out_data_nxt.last      = (idx_r == '0);
          if (idx_r != '0) begin
            idx_nxt = idx_r - FW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // Output register valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= uks_pkg::S_IDLE;
      fill_r      <= '0;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      dup_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
      dup_r       <= dup_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    key_r      <= key_nxt;
    value_r    <= value_nxt;
    out_data_r <= out_data_nxt;
  end

  // The fill level never passes the depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(STACK_DEPTH))
    else $error("fill level beyond stack depth");

  // A write happens only into a free slot.
  a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !full)
    else $error("write into a full stack");

  // An accepted push raises the fill level by one.
  a_push_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && state_r == uks_pkg::S_RESP && cmd_r == uks_pkg::CMD_PUSH
     && out_data_nxt.status == uks_pkg::STS_OK)
    |=> fill_r == $past(fill_r) + FW'(1))
    else $error("push did not advance the fill level");

  // The bottom entry of a display ends the transaction.
  a_disp_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && state_r == uks_pkg::S_DISP_OUT && out_data_nxt.last)
    |=> state_r == uks_pkg::S_IDLE)
    else $error("display did not finish after its last entry");

endmodule
